// ===== design/rob_pkg.sv =====
// Shared types and constants for the reorder buffer.
package rob_pkg;

  localparam int CYCLE_W = 32;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_EXEC   = 2'd1,
    REQ_RETIRE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } rob_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } rob_cmd_t;

endpackage

// ===== design/rob_ctrl.sv =====
// Controller state machine that sequences capture, execution and result hand-off.
module rob_ctrl import rob_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output rob_cmd_t cmd
);

  rob_state_t state_r;
  rob_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
        if (!out_stall) begin
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/rob_datapath.sv =====
// Entry memories, head and tail pointers, occupancy and the result register.
module rob_datapath import rob_pkg::*; #(
  parameter int DEPTH         = 10,
  parameter int PHYS_REG_BITS = 6,
  parameter int PTR_W         = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rob_cmd_t                 cmd,
  input  logic [1:0]               in_req_type,
  input  logic                     in_has_dest,
  input  logic [PHYS_REG_BITS-1:0] in_prev_phys_reg,
  input  logic [PTR_W-1:0]         in_entry_index,
  input  logic [CYCLE_W-1:0]       in_cycle,
  output logic [PTR_W-1:0]         out_alloc_index,
  output logic                     out_overflow,
  output logic                     out_retired,
  output logic                     out_free_valid,
  output logic [PHYS_REG_BITS-1:0] out_free_reg,
  output logic                     out_is_full,
  output logic                     out_is_empty
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  typedef struct packed {
    logic                     has_dest;
    logic [PHYS_REG_BITS-1:0] old_reg;
  } meta_t;

  typedef struct packed {
    logic               issued;
    logic [CYCLE_W-1:0] finish;
  } timing_t;

  meta_t   meta_mem [DEPTH];
  timing_t time_mem [DEPTH];

  // Captured request.
  req_t                     req_r;
  logic                     dest_r;
  logic [PHYS_REG_BITS-1:0] prev_r;
  logic [PTR_W-1:0]         idx_r;
  logic [CYCLE_W-1:0]       cyc_r;

  // Head entry, read when the request is captured.
  meta_t   meta_rd_r;
  timing_t time_rd_r;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;

  logic             alloc_ok;
  logic             exec_ok;
  logic             retire_ok;
  logic             time_we;
  logic [PTR_W-1:0] time_addr;
  timing_t          time_wdata;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= req_t'(in_req_type);
      dest_r    <= in_has_dest;
      prev_r    <= in_prev_phys_reg;
      idx_r     <= in_entry_index;
      cyc_r     <= in_cycle;
      meta_rd_r <= meta_mem[head_r];
      time_rd_r <= time_mem[head_r];
    end
  end

  always_comb begin
    alloc_ok  = (req_r == REQ_ALLOC) && (occ_r != FULL_OCC);
    exec_ok   = (req_r == REQ_EXEC) && (idx_r <= LAST_PTR);
    retire_ok = (req_r == REQ_RETIRE) && (occ_r != '0) && time_rd_r.issued &&
                (time_rd_r.finish <= cyc_r);

    time_we    = cmd.execute && (alloc_ok || exec_ok);
    time_addr  = alloc_ok ? tail_r : idx_r;
    time_wdata = alloc_ok ? '0 : timing_t'{issued: 1'b1, finish: cyc_r};

    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    if (alloc_ok) begin
      tail_nxt = (tail_r == LAST_PTR) ? '0 : tail_r + PTR_W'(1);
      occ_nxt  = occ_r + OCC_W'(1);
    end
    if (retire_ok) begin
      head_nxt = (head_r == LAST_PTR) ? '0 : head_r + PTR_W'(1);
      occ_nxt  = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && alloc_ok) begin
      meta_mem[tail_r] <= '{has_dest: dest_r, old_reg: prev_r};
    end
    if (time_we) begin
      time_mem[time_addr] <= time_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
    end else if (cmd.execute) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_alloc_index <= alloc_ok ? tail_r : '0;
      out_overflow    <= (req_r == REQ_ALLOC) && !alloc_ok;
      out_retired     <= retire_ok;
      out_free_valid  <= retire_ok && meta_rd_r.has_dest;
      out_free_reg    <= (retire_ok && meta_rd_r.has_dest) ? meta_rd_r.old_reg : '0;
      out_is_full     <= (occ_nxt == FULL_OCC);
      out_is_empty    <= (occ_nxt == '0);
    end
  end

endmodule

// ===== design/reorder_buffer.sv =====
// Top level of the reorder buffer: controller and datapath joined by commands.
//
// The block keeps a circular buffer of DEPTH instruction entries. Each request on
// the input channel is an allocate, an execute or a retire, and each request
// produces exactly one result on the output channel. Allocate appends an entry at
// the tail and returns its index, or flags overflow when the buffer is full.
// Execute marks any entry issued with its finish cycle. Retire frees the head
// entry when it is issued and its finish cycle is not later than the given cycle,
// and reports the old physical register it releases. Every result carries the
// full and empty status after the request. The unused request code changes nothing.
//
// A request is captured while the head entry is read from memory; in the execute
// state the request is decided, the buffer updated and the result registered, so
// the result is valid in the output state. No new request is taken before the
// pending result is taken, and a new request is accepted in the same cycle the
// pending result is taken. While the receiver stalls, the result holds and no new
// request is taken. Reset clears the pointers and occupancy, leaving the buffer
// empty; the entry memories need no clearing since only allocated entries are read.
module reorder_buffer import rob_pkg::*; #(
  parameter int DEPTH         = 10,
  parameter int PHYS_REG_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic                         in_has_dest,
  input  logic [PHYS_REG_BITS-1:0]     in_prev_phys_reg,
  input  logic [$clog2(DEPTH)-1:0]     in_entry_index,
  input  logic [CYCLE_W-1:0]           in_cycle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [$clog2(DEPTH)-1:0]     out_alloc_index,
  output logic                         out_overflow,
  output logic                         out_retired,
  output logic                         out_free_valid,
  output logic [PHYS_REG_BITS-1:0]     out_free_reg,
  output logic                         out_is_full,
  output logic                         out_is_empty
);

  rob_cmd_t cmd;

  // The controller only sequences; all buffer state lives in the datapath.
  rob_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rob_datapath #(
    .DEPTH         (DEPTH),
    .PHYS_REG_BITS (PHYS_REG_BITS),
    .PTR_W         ($clog2(DEPTH))
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_req_type      (in_req_type),
    .in_has_dest      (in_has_dest),
    .in_prev_phys_reg (in_prev_phys_reg),
    .in_entry_index   (in_entry_index),
    .in_cycle         (in_cycle),
    .out_alloc_index  (out_alloc_index),
    .out_overflow     (out_overflow),
    .out_retired      (out_retired),
    .out_free_valid   (out_free_valid),
    .out_free_reg     (out_free_reg),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty)
  );

endmodule
